// ----- hdl/ptis_pkg.sv -----
// ptis_pkg: shared types and constants for the parameter table interval search
// used by every module of the block but ptis_ram; no dependencies

package ptis_pkg;

  // default configuration
  localparam int TABLE_DEPTH = 256;
  localparam int PARAM_BITS  = 32;

  // beat and queue sizing
  localparam int VALUE_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // input beat as seen on the port
  typedef struct packed {
    logic                         op;
    logic signed [VALUE_BITS-1:0] param_value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [7:0] interval_index;
    logic [8:0] point_count;
    logic       table_empty;
    logic       error_flag;
  } res_item_t;

  // decoded command travelling through the queue
  typedef struct packed {
    op_e                          op;
    logic signed [VALUE_BITS-1:0] value;
  } cmd_t;

  // queue status towards the back end
  typedef struct packed {
    logic valid;
    cmd_t head;
  } queue_head_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_CHK,
    BS_DIV,
    BS_GUESS,
    BS_READ,
    BS_CMP
  } back_state_e;

endpackage

// ----- hdl/ptis_ram.sv -----
// ptis_ram: generic single write port, single read port ram with registered read
// no package dependencies

module ptis_ram #(
  parameter  int Width = 32,
  parameter  int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ptis_queue.sv -----
// ptis_queue: short command queue between the front end and the back end
// depends on ptis_pkg for the command type and queue depth

module ptis_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ptis_pkg::cmd_t        push_cmd_i,
  output logic                  full_o,
  output ptis_pkg::queue_head_t head_o,
  input  logic                  pop_i
);

  localparam int Depth = ptis_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  ptis_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o       = (fill_q == CntW'(Depth));
  assign head_o.valid = (fill_q != '0);
  assign head_o.head  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hdl/ptis_front.sv -----
// ptis_front: takes input beats, decodes the operation, sign-extends the low
// stored-width bits of the value and queues the command; depends on ptis_pkg

module ptis_front #(
  parameter int ParamBits = ptis_pkg::PARAM_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ptis_pkg::in_item_t in_item_i,
  output logic               push_o,
  output ptis_pkg::cmd_t     cmd_o,
  input  logic               full_i
);

  localparam int VW    = ptis_pkg::VALUE_BITS;
  localparam int SW    = (ParamBits < VW) ? ParamBits : VW;
  localparam int Shift = VW - SW;

  logic                 valid_q, valid_d;
  ptis_pkg::cmd_t       cmd_q, cmd_d;
  ptis_pkg::op_e        op_dec;
  logic signed [VW-1:0] val_shl;
  logic signed [VW-1:0] val_ext;
  logic                 accept;

  always_comb begin
    unique case (in_item_i.op)
      1'b0:    op_dec = ptis_pkg::OP_APPEND;
      1'b1:    op_dec = ptis_pkg::OP_QUERY;
      default: op_dec = ptis_pkg::OP_APPEND;
    endcase
  end

  // keep only the low stored-width bits, sign-extended
  assign val_shl = in_item_i.param_value <<< Shift;
  assign val_ext = val_shl >>> Shift;

  assign push_o = valid_q && !full_i;
  assign busy   = valid_q && full_i;
  assign accept = start && !busy;
  assign cmd_o  = cmd_q;

  always_comb begin
    valid_d = valid_q && !push_o;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d     = 1'b1;
      cmd_d.op    = op_dec;
      cmd_d.value = val_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ----- hdl/ptis_back.sv -----
// ptis_back: executes appends and interval queries against the value store
// depends on ptis_pkg and ptis_ram

module ptis_back #(
  parameter int TableDepth = ptis_pkg::TABLE_DEPTH,
  parameter int ParamBits  = ptis_pkg::PARAM_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptis_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  done_o,
  output ptis_pkg::res_item_t   res_o
);

  localparam int VW = ptis_pkg::VALUE_BITS;
  localparam int SW = (ParamBits < VW) ? ParamBits : VW;
  localparam int IW = $clog2(TableDepth);
  localparam int CW = $clog2(TableDepth + 1);
  localparam int PW = SW + 1 + IW;
  localparam int KW = (IW > 1) ? $clog2(IW) : 1;

  ptis_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic signed [SW-1:0] first_q, first_d;
  logic signed [SW-1:0] last_q, last_d;
  logic signed [SW-1:0] u_q, u_d;
  logic [SW:0]          dist_q, dist_d;
  logic [SW:0]          span_q, span_d;
  logic [IW-1:0]        nm1_q, nm1_d;
  logic [PW-1:0]        rem_q, rem_d;
  logic [PW-1:0]        div_q, div_d;
  logic [IW-1:0]        quo_q, quo_d;
  logic [KW-1:0]        k_q, k_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        guess_q, guess_d;
  logic                 down_q, down_d;
  logic                 walk_first_q, walk_first_d;
  logic                 done_q, done_d;
  ptis_pkg::res_item_t  res_q, res_d;

  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [SW-1:0]        ram_rdata;
  logic signed [SW-1:0] rd_val;

  logic signed [SW-1:0] head_u;
  logic signed [SW:0]   diff_uf;
  logic signed [SW:0]   diff_lf;
  logic [PW-1:0]        prod;
  logic                 is_query, few, at_end, flat, tbl_full;
  logic                 sat, div_last, dir_down, hit, walk_end;

  function automatic ptis_pkg::res_item_t make_res(logic [IW-1:0] idx,
                                                   logic [CW-1:0] cnt,
                                                   logic          err);
    ptis_pkg::res_item_t r;
    r.interval_index = 8'(idx);
    r.point_count    = 9'(cnt);
    r.table_empty    = (cnt == '0);
    r.error_flag     = err;
    return r;
  endfunction

  ptis_ram #(
    .Width (SW),
    .Depth (TableDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(count_q)),
    .wdata_i (head_u),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_val    = ram_rdata;
  assign ram_raddr = idx_q - 1'b1;

  assign head_u   = head_i.head.value[SW-1:0];
  assign diff_uf  = {head_u[SW-1], head_u} - {first_q[SW-1], first_q};
  assign diff_lf  = {last_q[SW-1], last_q} - {first_q[SW-1], first_q};
  assign prod     = PW'(dist_q) * PW'(nm1_q);

  assign is_query = (head_i.head.op == ptis_pkg::OP_QUERY);
  assign few      = (count_q < CW'(2));
  assign at_end   = (head_u >= last_q);
  assign flat     = (last_q <= first_q);
  assign tbl_full = (count_q == CW'(TableDepth));

  // quotient would not fit the index width, so the guess saturates
  assign sat      = (rem_q >= {span_q, {IW{1'b0}}});
  assign div_last = (k_q == '0);

  // first probe picks the walk direction, later probes keep it
  assign dir_down = walk_first_q ? (rd_val >= u_q) : down_q;
  assign hit      = dir_down ? (rd_val <= u_q) : (rd_val >= u_q);
  assign walk_end = dir_down ? (idx_q == IW'(1)) : (idx_q == nm1_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptis_pkg::BS_IDLE: begin
        if (head_i.valid && is_query && !few && !at_end && !flat) begin
          state_d = ptis_pkg::BS_MUL;
        end
      end
      ptis_pkg::BS_MUL:   state_d = ptis_pkg::BS_CHK;
      ptis_pkg::BS_CHK:   state_d = sat ? ptis_pkg::BS_READ : ptis_pkg::BS_DIV;
      ptis_pkg::BS_DIV:   state_d = div_last ? ptis_pkg::BS_GUESS : ptis_pkg::BS_DIV;
      ptis_pkg::BS_GUESS: state_d = ptis_pkg::BS_READ;
      ptis_pkg::BS_READ:  state_d = ptis_pkg::BS_CMP;
      ptis_pkg::BS_CMP:   state_d = (hit || walk_end) ? ptis_pkg::BS_IDLE : ptis_pkg::BS_READ;
      default:            state_d = ptis_pkg::BS_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d      = count_q;
    first_d      = first_q;
    last_d       = last_q;
    u_d          = u_q;
    dist_d       = dist_q;
    span_d       = span_q;
    nm1_d        = nm1_q;
    rem_d        = rem_q;
    div_d        = div_q;
    quo_d        = quo_q;
    k_d          = k_q;
    idx_d        = idx_q;
    guess_d      = guess_q;
    down_d       = down_q;
    walk_first_d = walk_first_q;
    done_d       = 1'b0;
    res_d        = res_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    unique case (state_q)
      ptis_pkg::BS_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          u_d    = head_u;
          nm1_d  = IW'(count_q - 1'b1);
          done_d = 1'b1;
          if (!is_query) begin
            if (tbl_full) begin
              res_d = make_res('0, count_q, 1'b1);
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
              last_d  = head_u;
              if (count_q == '0) begin
                first_d = head_u;
              end
              res_d = make_res('0, count_q + 1'b1, 1'b0);
            end
          end else if (few) begin
            res_d = make_res('0, count_q, 1'b1);
          end else if (at_end) begin
            res_d = make_res(IW'(count_q - 1'b1), count_q, 1'b0);
          end else if (flat) begin
            res_d = make_res(IW'(1), count_q, 1'b0);
          end else begin
            done_d = 1'b0;
            dist_d = diff_uf[SW] ? -diff_uf : diff_uf;
            span_d = diff_lf;
          end
        end
      end
      ptis_pkg::BS_MUL: begin
        rem_d = prod;
        div_d = PW'(span_q) << (IW - 1);
        quo_d = '0;
        k_d   = KW'(IW - 1);
      end
      ptis_pkg::BS_CHK: begin
        if (sat) begin
          idx_d        = nm1_q;
          guess_d      = nm1_q;
          walk_first_d = 1'b1;
        end
      end
      ptis_pkg::BS_DIV: begin
        // one quotient bit per cycle, most significant first
        if (rem_q >= div_q) begin
          rem_d = rem_q - div_q;
          quo_d = (quo_q << 1) | IW'(1);
        end else begin
          quo_d = quo_q << 1;
        end
        div_d = div_q >> 1;
        k_d   = k_q - 1'b1;
      end
      ptis_pkg::BS_GUESS: begin
        idx_d        = (quo_q >= nm1_q) ? nm1_q : quo_q + 1'b1;
        guess_d      = (quo_q >= nm1_q) ? nm1_q : quo_q + 1'b1;
        walk_first_d = 1'b1;
      end
      ptis_pkg::BS_READ: begin
        ram_re = 1'b1;
      end
      ptis_pkg::BS_CMP: begin
        walk_first_d = 1'b0;
        down_d       = dir_down;
        if (hit) begin
          done_d = 1'b1;
          res_d  = make_res(dir_down ? idx_q : idx_q - 1'b1, count_q, 1'b0);
        end else if (walk_end) begin
          // walked off the end without a bracket, fall back to the guess
          done_d = 1'b1;
          res_d  = make_res(guess_q, count_q, 1'b0);
        end else begin
          idx_d = dir_down ? idx_q - 1'b1 : idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptis_pkg::BS_IDLE;
      count_q      <= '0;
      done_q       <= 1'b0;
      walk_first_q <= 1'b0;
      down_q       <= 1'b0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      done_q       <= done_d;
      walk_first_q <= walk_first_d;
      down_q       <= down_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    u_q     <= u_d;
    dist_q  <= dist_d;
    span_q  <= span_d;
    nm1_q   <= nm1_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    quo_q   <= quo_d;
    idx_q   <= idx_d;
    guess_q <= guess_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- hdl/param_table_interval_search_top.sv -----
// param_table_interval_search_top: ascending parameter table with interval search
// depends on ptis_pkg, ptis_front, ptis_queue, ptis_back and ptis_ram
//
// channel   ports                      direction  handshake
// input     start, busy, in_item_i     in         beat taken when start & !busy
// result    done_o, res_o              out        beat valid for one cycle on done_o
//
// an append is handled in the idle state of the back end, as is a query that is
// settled at once (too few points, at or past the end, zero spacing); a full query
// forms its guess with one multiply, a saturation check and a divide (one quotient
// bit per cycle, skipped when the guess saturates), then probes stored values with
// a read and a compare each, as each probe waits on the registered read of the
// value store. the front stage and the queue each register a command; busy rises
// only when the queue is full. reset clears the count, so the table starts empty
// at once. results cannot be held off, so the back end never stalls on its output

module param_table_interval_search_top #(
  parameter int TableDepth = ptis_pkg::TABLE_DEPTH,
  parameter int ParamBits  = ptis_pkg::PARAM_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ptis_pkg::in_item_t  in_item_i,
  output logic                done_o,
  output ptis_pkg::res_item_t res_o
);

  logic                  push;
  ptis_pkg::cmd_t        cmd;
  logic                  q_full;
  ptis_pkg::queue_head_t q_head;
  logic                  pop;

  ptis_front #(
    .ParamBits (ParamBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_item_i (in_item_i),
    .push_o    (push),
    .cmd_o     (cmd),
    .full_i    (q_full)
  );

  ptis_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (cmd),
    .full_o     (q_full),
    .head_o     (q_head),
    .pop_i      (pop)
  );

  ptis_back #(
    .TableDepth (TableDepth),
    .ParamBits  (ParamBits)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (pop),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
